// ===== hdl/frame_rle_encoder_macros.svh =====
// Assertion macros for the frame RLE encoder.
// Included by the top level; expects a clock and an active-high reset name.
`ifndef FRAME_RLE_ENCODER_MACROS_SVH
`define FRAME_RLE_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

`define FRLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frame_rle_encoder assertion failed");

`define FRLE_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("frame_rle_encoder forbidden condition seen");

`else

`define FRLE_ASSERT(label, clk, rst, prop)
`define FRLE_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hdl/frle_pkg.sv =====
// Shared types and constants for the frame RLE encoder.
// No dependencies; used by frle_step and frame_rle_encoder.
`timescale 1ns / 1ps

package frle_pkg;

   localparam int unsigned LEN_W = 21;
   localparam logic [LEN_W-1:0] MAX_PACKED_BYTES = 21'd1048576;
   localparam logic [LEN_W-1:0] BYTE_LIMIT_RESET = 21'd1048576;

   localparam logic [7:0] TRANSPARENT_VALUE = 8'd254;
   localparam logic [7:0] HIGH_FLAG = 8'h80;
   localparam logic [8:0] HIGH_RUN_MAX = 9'd127;
   localparam logic [8:0] ESC_RUN_MAX = 9'd255;
   localparam logic [8:0] ESC_MIN_RUN = 9'd3;

   localparam int unsigned MAX_RESULTS = 8;
   localparam int unsigned RES_IDX_W = 3;
   localparam int unsigned RES_CNT_W = 4;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 21;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_CODE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT = 2'd3;

   typedef struct packed {
      logic [7:0] pixel;
      logic [7:0] previous_pixel;
      logic       frame_start;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             frame_done;
      logic             overflow;
      logic [LEN_W-1:0] packed_length;
      logic             run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [7:0]       marker_code;
      logic [7:0]       header_code;
      logic [LEN_W-1:0] byte_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       held_value;
      logic             held_valid;
      logic [8:0]       run_count;
      logic [LEN_W-1:0] byte_total;
      logic             aborted;
   } state_type;

endpackage

// ===== hdl/frle_step.sv =====
// Per-item encode logic: from the current run state, config and one pixel,
// builds the list of result items and the next run state. Uses frle_pkg.
`timescale 1ns / 1ps

module frle_step (
   input  frle_pkg::req_type                               item,
   input  frle_pkg::cfg_type                               cfg,
   input  frle_pkg::state_type                             state,
   output frle_pkg::state_type                             state_next,
   output frle_pkg::rsp_type [frle_pkg::MAX_RESULTS-1:0]   results,
   output logic [frle_pkg::RES_CNT_W-1:0]                  count
);

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } flush_type;

   function automatic flush_type flush_escape(logic [8:0] c, logic [7:0] v,
                                              logic [7:0] marker);
      flush_type f;
      f = '0;
      if (c == 9'd0) begin
         f = '0;
      end else if (c < frle_pkg::ESC_MIN_RUN) begin
         if (v == marker) begin
            // short run of the marker itself still needs the escape pair
            f.bytes[0] = marker;
            f.bytes[1] = 8'(c - 9'd1);
            f.count    = 2'd2;
         end else begin
            f.bytes[0] = v;
            f.bytes[1] = v;
            f.count    = c[1:0];
         end
      end else begin
         f.bytes[0] = marker;
         f.bytes[1] = 8'(c - 9'd1);
         f.bytes[2] = v;
         f.count    = 2'd3;
      end
      return f;
   endfunction

   function automatic flush_type flush_high(logic [8:0] c, logic [7:0] v);
      flush_type f;
      f = '0;
      if (c == 9'd0) begin
         f = '0;
      end else if (c == 9'd1 && !v[7]) begin
         f.bytes[0] = v;
         f.count    = 2'd1;
      end else begin
         f.bytes[0] = c[7:0] | frle_pkg::HIGH_FLAG;
         f.bytes[1] = v;
         f.count    = 2'd2;
      end
      return f;
   endfunction

   function automatic logic near_limit(logic [frle_pkg::LEN_W-1:0] total, logic [1:0] add,
                                       logic [frle_pkg::LEN_W-1:0] lim);
      logic [frle_pkg::LEN_W:0] sum;
      sum = {1'b0, total} + (frle_pkg::LEN_W+1)'(add);
      return sum >= {1'b0, lim};
   endfunction

   function automatic frle_pkg::rsp_type data_item(logic [7:0] b);
      frle_pkg::rsp_type r;
      r = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      return r;
   endfunction

   always_comb begin
      frle_pkg::state_type st;
      flush_type fb;
      flush_type fe;
      logic hdr;
      logic stat;
      logic ovf;
      logic high;
      logic abort;
      logic [7:0] v;
      logic [frle_pkg::LEN_W-1:0] lim;
      logic [frle_pkg::LEN_W-1:0] len;
      logic [frle_pkg::RES_CNT_W-1:0] n;
      logic [frle_pkg::RES_CNT_W-1:0] last;

      st    = state;
      fb    = '0;
      fe    = '0;
      hdr   = 1'b0;
      stat  = 1'b0;
      ovf   = 1'b0;
      abort = 1'b0;
      len   = '0;
      high  = cfg.mode[0];
      lim   = (cfg.byte_limit > frle_pkg::MAX_PACKED_BYTES) ?
              frle_pkg::MAX_PACKED_BYTES : cfg.byte_limit;
      v     = (cfg.mode[1] && item.pixel == item.previous_pixel) ?
              frle_pkg::TRANSPARENT_VALUE : item.pixel;

      if (item.frame_start) begin
         st.held_valid = 1'b0;
         st.run_count  = '0;
         st.byte_total = frle_pkg::LEN_W'(1);
         st.aborted    = 1'b0;
         hdr           = 1'b1;
      end

      if (st.byte_total != '0 && !st.aborted) begin
         if (!high) begin
            if (!st.held_valid || v != st.held_value
                || st.run_count > frle_pkg::ESC_RUN_MAX) begin
               if (near_limit(st.byte_total, 2'd3, lim)) begin
                  abort = 1'b1;
               end else begin
                  fb = flush_escape(st.run_count, st.held_value, cfg.marker_code);
                  st.byte_total = st.byte_total + frle_pkg::LEN_W'(fb.count);
                  st.held_value = v;
                  st.held_valid = 1'b1;
                  st.run_count  = '0;
               end
            end
            if (!abort) begin
               st.run_count = st.run_count + 9'd1;
            end
         end else if (!st.held_valid) begin
            st.held_value = v;
            st.held_valid = 1'b1;
            st.run_count  = 9'd1;
         end else begin
            if (v != st.held_value) begin
               if (st.run_count != '0) begin
                  if (near_limit(st.byte_total, 2'd2, lim)) begin
                     abort = 1'b1;
                  end else begin
                     fb = flush_high(st.run_count, st.held_value);
                     st.byte_total = st.byte_total + frle_pkg::LEN_W'(fb.count);
                  end
               end
               if (!abort) begin
                  st.held_value = v;
                  st.run_count  = '0;
               end
            end
            if (!abort) begin
               st.run_count = st.run_count + 9'd1;
               // force the run out before the count byte runs out of bits
               if (st.run_count >= frle_pkg::HIGH_RUN_MAX) begin
                  if (near_limit(st.byte_total, 2'd2, lim)) begin
                     abort = 1'b1;
                  end else begin
                     fb = flush_high(st.run_count, st.held_value);
                     st.byte_total = st.byte_total + frle_pkg::LEN_W'(fb.count);
                     st.run_count  = '0;
                  end
               end
            end
         end

         if (item.frame_end && !abort) begin
            if (!high) begin
               if (near_limit(st.byte_total, 2'd3, lim)) begin
                  abort = 1'b1;
               end else begin
                  fe = flush_escape(st.run_count, st.held_value, cfg.marker_code);
                  st.byte_total = st.byte_total + frle_pkg::LEN_W'(fe.count);
               end
            end else if (st.run_count != '0) begin
               if (near_limit(st.byte_total, 2'd2, lim)) begin
                  abort = 1'b1;
               end else begin
                  fe = flush_high(st.run_count, st.held_value);
                  st.byte_total = st.byte_total + frle_pkg::LEN_W'(fe.count);
               end
            end
            if (!abort) begin
               stat          = 1'b1;
               len           = st.byte_total;
               st.held_valid = 1'b0;
               st.run_count  = '0;
               st.byte_total = '0;
            end
         end

         if (abort) begin
            stat          = 1'b1;
            ovf           = 1'b1;
            st.held_valid = 1'b0;
            st.run_count  = '0;
            st.byte_total = '0;
            st.aborted    = 1'b1;
         end
      end

      // pack the results in emission order
      results = '0;
      n       = '0;
      if (hdr) begin
         results[n[frle_pkg::RES_IDX_W-1:0]] = data_item(cfg.header_code);
         n = n + 4'd1;
      end
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < fb.count) begin
            results[n[frle_pkg::RES_IDX_W-1:0]] = data_item(fb.bytes[i]);
            n = n + 4'd1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < fe.count) begin
            results[n[frle_pkg::RES_IDX_W-1:0]] = data_item(fe.bytes[i]);
            n = n + 4'd1;
         end
      end
      if (stat) begin
         results[n[frle_pkg::RES_IDX_W-1:0]].frame_done    = 1'b1;
         results[n[frle_pkg::RES_IDX_W-1:0]].overflow      = ovf;
         results[n[frle_pkg::RES_IDX_W-1:0]].packed_length = len;
         n = n + 4'd1;
      end
      last = n - 4'd1;
      if (n != '0) begin
         results[last[frle_pkg::RES_IDX_W-1:0]].run_last = 1'b1;
      end

      count      = n;
      state_next = st;
   end

endmodule

// ===== hdl/frame_rle_encoder.sv =====
// Frame RLE encoder top level: input register, run state, result list and
// byte serializer. Uses frle_pkg, frle_step and frame_rle_encoder_macros.svh.
`timescale 1ns / 1ps
`include "frame_rle_encoder_macros.svh"

// Usage:
//   req_valid/req_stall/req_data carry one pixel item (pixel, previous-frame
//   pixel, frame_start, frame_end). rsp_valid/rsp_stall/rsp_data carry one
//   result item per cycle while rsp_stall is low: a packed byte, or a status item closing a frame
//   with frame_done, overflow and packed_length. run_last marks the last
//   result caused by an input item.
//   csr_wr_en/csr_index/csr_wdata write mode, marker_code, header_code and
//   byte_limit; write them only while the block is idle.
//   An accepted item is held in the input register and encoded from there,
//   once the result list is free, into a list of up to 8 results; the list
//   is registered and the first result is shown from the list register.
//   The input register can take the next item while the results of the
//   previous one are still sent over the single result port. The next item
//   is encoded in the cycle the last result of the previous one is taken,
//   so the output runs without gaps while items with results wait.
//   A stalled receiver holds the current result; the input register then
//   fills and req_stall rises. Reset clears the run state, drops pending
//   results and restores the register defaults.
module frame_rle_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  frle_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output frle_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [frle_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [frle_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   frle_pkg::req_type                           in_ff;
   logic                                        in_valid_ff;
   logic                                        in_valid_in;
   frle_pkg::cfg_type                           cfg_ff;
   frle_pkg::state_type                         state_ff;
   frle_pkg::state_type                         state_in;
   frle_pkg::rsp_type [frle_pkg::MAX_RESULTS-1:0] list_ff;
   frle_pkg::rsp_type [frle_pkg::MAX_RESULTS-1:0] list_in;
   logic [frle_pkg::RES_CNT_W-1:0]              rem_ff;
   logic [frle_pkg::RES_CNT_W-1:0]              list_count;
   logic [frle_pkg::RES_IDX_W-1:0]              idx_ff;
   logic                                        req_take;
   logic                                        rsp_take;
   logic                                        drained;
   logic                                        load;

   frle_step u_step (
      .item       (in_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .results    (list_in),
      .count      (list_count)
   );

   assign rsp_valid = (rem_ff != '0);
   assign rsp_data  = list_ff[idx_ff];
   assign rsp_take  = rsp_valid && !rsp_stall;
   // list is free once its last item leaves this cycle
   assign drained   = (rem_ff == '0) || (rem_ff == 4'd1 && !rsp_stall);
   assign load      = in_valid_ff && drained;
   assign req_stall = in_valid_ff && !load;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= '0;
         cfg_ff.marker_code <= '0;
         cfg_ff.header_code <= '0;
         cfg_ff.byte_limit  <= frle_pkg::BYTE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            frle_pkg::CSR_MODE:        cfg_ff.mode        <= csr_wdata[1:0];
            frle_pkg::CSR_MARKER_CODE: cfg_ff.marker_code <= csr_wdata[7:0];
            frle_pkg::CSR_HEADER_CODE: cfg_ff.header_code <= csr_wdata[7:0];
            frle_pkg::CSR_BYTE_LIMIT:  cfg_ff.byte_limit  <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rem_ff   <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         state_ff <= state_in;
         rem_ff   <= list_count;
         idx_ff   <= '0;
      end else if (rsp_take) begin
         rem_ff   <= rem_ff - 4'd1;
         idx_ff   <= idx_ff + 3'd1;
      end
      if (load) begin
         list_ff <= list_in;
      end
   end

   `FRLE_ASSERT_NEVER(a_rem_bound, clock, reset, rem_ff > 4'd8)
   `FRLE_ASSERT(a_run_last_matches, clock, reset,
      rsp_valid |-> (rsp_data.run_last == (rem_ff == 4'd1)))
   `FRLE_ASSERT(a_status_has_no_byte, clock, reset,
      (rsp_valid && rsp_data.frame_done) |-> !rsp_data.byte_valid)
   `FRLE_ASSERT(a_abort_closes_frame, clock, reset,
      state_ff.aborted |-> (state_ff.byte_total == '0 && !state_ff.held_valid))

endmodule

// ===== tb/sv/tb_frame_rle_encoder.sv =====
// Self-checking testbench for frame_rle_encoder: pixel items in, packed bytes out.
// A local run-length predictor checks every result item in order.
// Depends on frle_pkg and the frame_rle_encoder RTL.
`timescale 1ns / 1ps

module tb_frame_rle_encoder;
   import frle_pkg::*;

   localparam logic [1:0] MODE_KEY_ESC    = 2'd0;
   localparam logic [1:0] MODE_KEY_HIGH   = 2'd1;
   localparam logic [1:0] MODE_DELTA_ESC  = 2'd2;
   localparam logic [1:0] MODE_DELTA_HIGH = 2'd3;

   localparam logic [CSR_DATA_W-1:0] LIMIT_MIN = 21'd2;
   localparam logic [CSR_DATA_W-1:0] LIMIT_TOP = 21'h1FFFFF;

   localparam int ITEM_TARGET   = 150;
   localparam int LONG_RUN      = 128;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 200000;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   frame_rle_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [1:0]       cfg_mode   = 2'd0;
   logic [7:0]       cfg_marker = 8'd0;
   logic [7:0]       cfg_header = 8'd0;
   logic [LEN_W-1:0] cfg_limit  = BYTE_LIMIT_RESET;

   // encoder state copy
   logic [7:0]  held_value    = 8'd0;
   logic        held_valid    = 1'b0;
   logic [8:0]  run_count     = 9'd0;
   int unsigned byte_total    = 0;
   logic        frame_aborted = 1'b0;

   req_type pixel_items[$];
   rsp_type step_results[$];
   rsp_type predicted_stream[$];
   rsp_type next_result;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  no_idle        = 1'b0;
   bit  hold_request   = 1'b0;
   bit  hold_used      = 1'b0;
   int  hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void emit_byte(input logic [7:0] value);
      rsp_type r;
      r = '0;
      r.out_byte = value;
      r.byte_valid = 1'b1;
      step_results.push_back(r);
   endfunction

   function automatic void emit_status(input logic ovf, input int unsigned length);
      rsp_type r;
      r = '0;
      r.frame_done = 1'b1;
      r.overflow = ovf;
      r.packed_length = length[LEN_W-1:0];
      step_results.push_back(r);
   endfunction

   function automatic void clear_frame();
      held_valid = 1'b0;
      run_count = 9'd0;
      byte_total = 0;
   endfunction

   function automatic void close_escape_run();
      logic [8:0] count_m1;
      count_m1 = run_count - 9'd1;
      if (run_count == 9'd0) return;
      if (run_count < ESC_MIN_RUN) begin
         // a short run of the marker value itself must still be escaped
         if (held_value == cfg_marker) begin
            emit_byte(cfg_marker);
            emit_byte(count_m1[7:0]);
            byte_total += 2;
         end else begin
            for (int k = 0; k < run_count; k++) emit_byte(held_value);
            byte_total += run_count;
         end
      end else begin
         emit_byte(cfg_marker);
         emit_byte(count_m1[7:0]);
         emit_byte(held_value);
         byte_total += 3;
      end
   endfunction

   function automatic void close_highbit_run();
      if (run_count == 9'd0) return;
      if (run_count == 9'd1 && !held_value[7]) begin
         emit_byte(held_value);
         byte_total += 1;
      end else begin
         emit_byte(run_count[7:0] | HIGH_FLAG);
         emit_byte(held_value);
         byte_total += 2;
      end
   endfunction

   function automatic void encode_pixel(input req_type item);
      logic [7:0]  value;
      logic        high;
      bit          over;
      int unsigned lim;
      rsp_type     r;
      step_results.delete();
      high = cfg_mode[0];
      over = 1'b0;
      lim = (cfg_limit > MAX_PACKED_BYTES) ? MAX_PACKED_BYTES : cfg_limit;
      if (item.frame_start) begin
         clear_frame();
         frame_aborted = 1'b0;
         byte_total = 1;
         emit_byte(cfg_header);
      end
      if (byte_total != 0 && !frame_aborted) begin
         value = (cfg_mode[1] && item.pixel == item.previous_pixel) ?
                 TRANSPARENT_VALUE : item.pixel;
         if (!high) begin
            if (!held_valid || value != held_value || run_count > ESC_RUN_MAX) begin
               if (byte_total + 3 >= lim) over = 1'b1;
               else begin
                  close_escape_run();
                  held_value = value;
                  held_valid = 1'b1;
                  run_count = 9'd0;
               end
            end
            if (!over) run_count = run_count + 9'd1;
         end else if (!held_valid) begin
            held_value = value;
            held_valid = 1'b1;
            run_count = 9'd1;
         end else begin
            if (value != held_value) begin
               if (run_count != 0 && byte_total + 2 >= lim) over = 1'b1;
               else begin
                  close_highbit_run();
                  held_value = value;
                  run_count = 9'd0;
               end
            end
            if (!over) begin
               run_count = run_count + 9'd1;
               // force the run out at the high-bit count ceiling
               if (run_count >= HIGH_RUN_MAX) begin
                  if (byte_total + 2 >= lim) over = 1'b1;
                  else begin
                     close_highbit_run();
                     run_count = 9'd0;
                  end
               end
            end
         end
         if (!over && item.frame_end) begin
            if (!high) begin
               if (byte_total + 3 >= lim) over = 1'b1;
               else close_escape_run();
            end else if (run_count != 0) begin
               if (byte_total + 2 >= lim) over = 1'b1;
               else close_highbit_run();
            end
            if (!over) begin
               emit_status(1'b0, byte_total);
               clear_frame();
            end
         end
         if (over) begin
            emit_status(1'b1, 0);
            clear_frame();
            frame_aborted = 1'b1;
         end
      end
      for (int i = 0; i < step_results.size(); i++) begin
         r = step_results[i];
         r.run_last = (i == step_results.size() - 1);
         predicted_stream.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_pixel(req_data);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_items.size() != 0 && !(!no_idle && $urandom_range(99) < 6)) begin
               req_valid <= 1'b1;
               req_data <= pixel_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_stream.size() == 0) begin
               $error("unexpected result item: out_byte %0h byte_valid %0b frame_done %0b",
                      rsp_data.out_byte, rsp_data.byte_valid, rsp_data.frame_done);
               mismatch_count++;
            end else begin
               next_result = predicted_stream.pop_front();
               if (rsp_data.out_byte !== next_result.out_byte) begin
                  $error("out_byte expected %0h actual %0h",
                         next_result.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.byte_valid !== next_result.byte_valid) begin
                  $error("byte_valid expected %0b actual %0b",
                         next_result.byte_valid, rsp_data.byte_valid);
                  mismatch_count++;
               end
               if (rsp_data.frame_done !== next_result.frame_done) begin
                  $error("frame_done expected %0b actual %0b",
                         next_result.frame_done, rsp_data.frame_done);
                  mismatch_count++;
               end
               if (rsp_data.overflow !== next_result.overflow) begin
                  $error("overflow expected %0b actual %0b",
                         next_result.overflow, rsp_data.overflow);
                  mismatch_count++;
               end
               if (rsp_data.packed_length !== next_result.packed_length) begin
                  $error("packed_length expected %0d actual %0d",
                         next_result.packed_length, rsp_data.packed_length);
                  mismatch_count++;
               end
               if (rsp_data.run_last !== next_result.run_last) begin
                  $error("run_last expected %0b actual %0b",
                         next_result.run_last, rsp_data.run_last);
                  mismatch_count++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 6);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MODE:        cfg_mode = data[1:0];
         CSR_MARKER_CODE: cfg_marker = data[7:0];
         CSR_HEADER_CODE: cfg_header = data[7:0];
         CSR_BYTE_LIMIT:  cfg_limit = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [7:0] marker,
                             input logic [7:0] header, input logic [CSR_DATA_W-1:0] limit);
      write_reg(CSR_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_MARKER_CODE, CSR_DATA_W'(marker));
      write_reg(CSR_HEADER_CODE, CSR_DATA_W'(header));
      write_reg(CSR_BYTE_LIMIT, limit);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_item(input logic [7:0] pixel, input logic [7:0] prev,
                             input logic start, input logic last);
      req_type item;
      item.pixel = pixel;
      item.previous_pixel = prev;
      item.frame_start = start;
      item.frame_end = last;
      pixel_items.push_back(item);
      queued_count++;
   endtask

   // hold until every item is in and every result is out, then let
   // zero-result items clear the pipeline
   task automatic wait_drained();
      while (accepted_count != queued_count || predicted_stream.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_value();
      case ($urandom_range(7))
         0: return cfg_marker;
         1: return TRANSPARENT_VALUE;
         2: return 8'h00;
         3: return 8'hFF;
         4: return 8'h7F;
         5: return 8'h80;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_frame(input int pixels, input int run_max,
                              input bit with_start, input bit with_end);
      int left;
      int run;
      logic [7:0] value;
      logic [7:0] prev;
      left = pixels;
      while (left > 0) begin
         run = $urandom_range(run_max, 1);
         if (run > left) run = left;
         value = pick_value();
         repeat (run) begin
            prev = $urandom_range(1) ? value : 8'($urandom_range(255));
            queue_item(value, prev, with_start && left == pixels, with_end && left == 1);
            left--;
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int pixels;
      logic [7:0] marker;
      logic [7:0] header;
      logic [7:0] run_value;
      logic [CSR_DATA_W-1:0] limit;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // key escape: stray pixel, one-pixel frame, literals, escaped marker,
      // a real run, restart inside an open frame
      set_config(MODE_KEY_ESC, 8'hA5, 8'h3C, MAX_PACKED_BYTES);
      queue_item(8'hFF, 8'h00, 1'b0, 1'b0);
      queue_item(8'h11, 8'h11, 1'b1, 1'b1);
      queue_item(8'h00, 8'hFF, 1'b1, 1'b0);
      queue_item(8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(8'hA5, 8'h5A, 1'b0, 1'b0);
      repeat (3) queue_item(8'h33, 8'hCC, 1'b0, 1'b0);
      queue_item(8'h80, 8'h7F, 1'b0, 1'b1);
      queue_item(8'h44, 8'h00, 1'b1, 1'b0);
      queue_item(8'h44, 8'h00, 1'b0, 1'b0);
      queue_item(8'h55, 8'h00, 1'b1, 1'b1);
      wait_drained();

      // key high-bit: plain literal, literal with bit 7 set, short run
      set_config(MODE_KEY_HIGH, 8'h00, 8'hFF, MAX_PACKED_BYTES);
      queue_item(8'h05, 8'h00, 1'b1, 1'b0);
      queue_item(8'h85, 8'h00, 1'b0, 1'b0);
      queue_item(8'h05, 8'h00, 1'b0, 1'b0);
      queue_item(8'h05, 8'h00, 1'b0, 1'b0);
      queue_item(8'h7F, 8'h00, 1'b0, 1'b1);
      queue_item(8'h80, 8'h80, 1'b1, 1'b1);
      wait_drained();

      // delta escape with the marker on the transparent value
      set_config(MODE_DELTA_ESC, TRANSPARENT_VALUE, 8'h01, MAX_PACKED_BYTES);
      queue_item(8'h10, 8'h10, 1'b1, 1'b0);
      queue_item(8'h20, 8'h20, 1'b0, 1'b0);
      queue_item(8'h20, 8'h21, 1'b0, 1'b1);
      wait_drained();

      // delta high-bit: the first pixel is replaced too
      set_config(MODE_DELTA_HIGH, 8'h00, 8'h00, MAX_PACKED_BYTES);
      queue_item(8'h90, 8'h90, 1'b1, 1'b0);
      queue_item(8'h90, 8'h00, 1'b0, 1'b0);
      queue_item(8'h90, 8'h90, 1'b0, 1'b1);
      wait_drained();

      // overflow in both formats; the rest of the frame is dropped
      set_config(MODE_KEY_ESC, 8'hA5, 8'h3C, LIMIT_MIN);
      queue_item(8'h01, 8'h00, 1'b1, 1'b0);
      queue_item(8'h01, 8'h00, 1'b0, 1'b1);
      wait_drained();
      set_config(MODE_KEY_HIGH, 8'hA5, 8'h3C, 21'd4);
      queue_item(8'h01, 8'h00, 1'b1, 1'b0);
      queue_item(8'h02, 8'h00, 1'b0, 1'b0);
      queue_item(8'h03, 8'h00, 1'b0, 1'b0);
      queue_item(8'h04, 8'h00, 1'b0, 1'b1);
      wait_drained();

      phase = 0;
      while (queued_count < ITEM_TARGET || phase < 4) begin
         case ($urandom_range(2))
            0: marker = 8'h00;
            1: marker = 8'hFF;
            default: marker = 8'($urandom_range(255));
         endcase
         case ($urandom_range(2))
            0: header = 8'h00;
            1: header = 8'hFF;
            default: header = 8'($urandom_range(255));
         endcase
         case ($urandom_range(5))
            0: limit = LIMIT_MIN;
            1: limit = CSR_DATA_W'($urandom_range(40, 3));
            2: limit = MAX_PACKED_BYTES;
            3: limit = LIMIT_TOP;
            4: limit = CSR_DATA_W'($urandom_range(MAX_PACKED_BYTES, 41));
            default: limit = CSR_DATA_W'($urandom_range(14, 6));
         endcase
         // the first phases walk through every mode once
         set_config(phase < 4 ? 2'(phase) : 2'($urandom_range(3)), marker, header,
                    phase == 1 ? MAX_PACKED_BYTES : limit);

         if (phase == 1) begin
            // hold off the receiver and stream one run past the high-bit ceiling
            hold_request <= 1'b1;
            no_idle <= 1'b1;
            run_value = pick_value();
            for (int k = 0; k < LONG_RUN; k++)
               queue_item(run_value, run_value, k == 0, k == LONG_RUN - 1);
         end else begin
            repeat ($urandom_range(3, 1)) begin
               pixels = $urandom_range(12, 1);
               case ($urandom_range(9))
                  0: begin
                     repeat (3) queue_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                                           1'($urandom_range(1)), 1'($urandom_range(1)));
                  end
                  1: queue_frame(pixels, 6, 1'b1, 1'b0);
                  2: queue_frame(pixels, 6, 1'b0, 1'b1);
                  default: queue_frame(pixels, 6, 1'b1, 1'b1);
               endcase
            end
         end
         wait_drained();
         no_idle <= 1'b0;
         phase++;
      end

      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/frle_pkg.sv
hdl/frle_step.sv
hdl/frame_rle_encoder.sv
tb/sv/tb_frame_rle_encoder.sv
